// ----- hw/rtl/cma_pkg.sv -----
// Shared types and constants for the centered moving average block.
`default_nettype none
package cma_pkg;

  // Configuration register file
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned HALF_W   = 5;
  localparam logic [HALF_W-1:0] HALF_RESET = 5'd2;

  // Word index of each configuration register
  localparam logic REG_HALF_WIDTH = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV,
    ST_EMIT
  } cma_state_e;

endpackage
`default_nettype wire

// ----- hw/rtl/cma_line.sv -----
// Sample ring memory: one write port, one registered read port.
`default_nettype none
module cma_line #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 63,
  parameter int unsigned AW     = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cma_div.sv -----
// Serial restoring divider: signed dividend by positive divisor, one bit per cycle.
`default_nettype none
module cma_div #(
  parameter int unsigned SUM_W = 30,
  parameter int unsigned DIV_W = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [SUM_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DIV_W:0]   rem_shift;

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    neg_d     = neg_q;
    rem_shift = {rem_q, quo_q[SUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
    end else if (busy_q) begin
      // Shift in the next dividend bit and subtract where it fits
      if (rem_shift >= {1'b0, dvs_q}) begin
        rem_d = DIV_W'(rem_shift - {1'b0, dvs_q});
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DIV_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

endmodule
`default_nettype wire

// ----- hw/rtl/centered_moving_average.sv -----
// Top level: centered boxcar mean with shrinking edges, sequencer and register port.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------
//  input    | in        | in_valid_i / in_stall_o    | sample_i, last_sample_i
//  output   | out       | out_valid_o / out_stall_i  | smoothed_o, last_result_o
//  config   | in        | APB psel/penable/pready    | half_width at byte address 0
//
// For each result that an item releases, the window is summed through the single ring read port
// and then divided in the serial divider, plus bookkeeping.
// in_stall_o stays high from acceptance until the sequencer is back in idle, which it
// reaches through its check step after the last result of the item is loaded.
// A stalled output holds the sequencer in its emit step; reset needs no clearing pass.
`default_nettype none
module centered_moving_average #(
  parameter int unsigned MAX_HALF    = 31,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                         last_sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     smoothed_o,
  output logic                              last_result_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cma_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cma_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cma_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  import cma_pkg::*;

  localparam int unsigned LINE_DEPTH = 2 * MAX_HALF + 1;
  localparam int unsigned PTR_W      = $clog2(LINE_DEPTH);
  localparam int unsigned PEND_W     = $clog2(MAX_HALF + 2);
  localparam int unsigned H_W        = $clog2(MAX_HALF + 1);
  localparam int unsigned CNT_W      = $clog2(LINE_DEPTH);
  localparam int unsigned SUM_W      = SAMPLE_BITS + $clog2(LINE_DEPTH);
  localparam int unsigned DIV_W      = $clog2(LINE_DEPTH + 1);

  cma_state_e state_q, state_d;

  logic [HALF_W-1:0]      half_width_q;
  logic [PTR_W-1:0]       wr_ptr_q;
  logic [PEND_W-1:0]      pending_q;
  logic [H_W-1:0]         outputs_done_q;
  logic                   flush_q;
  logic [H_W-1:0]         h_q;
  logic                   last_res_q;
  logic [PTR_W-1:0]       rd_addr_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   rd_valid_q;
  logic [SUM_W-1:0]       acc_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] smoothed_q;
  logic                   out_last_q;

  logic                   in_accept;
  logic                   cfg_write;
  logic [H_W-1:0]         heff;
  logic [H_W-1:0]         h_full;
  logic [PEND_W-1:0]      pend_m1;
  logic [H_W-1:0]         h_sel;
  logic                   emit_now;
  logic [31:0]            start_addr;
  logic                   sum_last;
  logic                   out_free;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SUM_W-1:0]       quotient;
  logic                   div_start;
  logic                   div_done;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_RESET;
    end else if (cfg_write && (paddr[2] == REG_HALF_WIDTH)) begin
      half_width_q <= pwdata[HALF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HALF_WIDTH) begin
      prdata = PDATA_W'(half_width_q);
    end
  end

  // ---------------------------------------------------------------- window selection
  assign in_accept = in_valid_i && !in_stall_o;
  assign heff      = (32'(half_width_q) > 32'(MAX_HALF)) ? H_W'(MAX_HALF) : H_W'(half_width_q);
  assign h_full    = (outputs_done_q < heff) ? outputs_done_q : heff;
  assign pend_m1   = pending_q - PEND_W'(1);

  always_comb begin
    h_sel    = h_full;
    emit_now = 1'b0;
    if (pending_q != '0) begin
      if (flush_q) begin
        emit_now = 1'b1;
        if (32'(pend_m1) < 32'(h_full)) begin
          h_sel = H_W'(pend_m1);
        end
      end else begin
        emit_now = (32'(pend_m1) >= 32'(h_full));
      end
    end
  end

  // Oldest sample of the window: wr_ptr - pending - h, modulo the ring depth
  always_comb begin
    start_addr = 32'(wr_ptr_q) + 32'(LINE_DEPTH) - 32'(pending_q) - 32'(h_sel);
    if (start_addr >= 32'(LINE_DEPTH)) begin
      start_addr = start_addr - 32'(LINE_DEPTH);
    end
  end

  assign sum_last = (32'(cnt_q) == 2 * 32'(h_q));
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = emit_now ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (sum_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_DIV_GO: div_start  = 1'b1;
      ST_EMIT:   out_load   = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      wr_ptr_q       <= '0;
      pending_q      <= '0;
      outputs_done_q <= '0;
      flush_q        <= 1'b0;
      rd_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= (state_q == ST_SUM);
      if (in_accept) begin
        wr_ptr_q  <= (32'(wr_ptr_q) == LINE_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
        pending_q <= pending_q + PEND_W'(1);
        flush_q   <= last_sample_i;
      end
      // End of trace: drop the per-trace counts
      if ((state_q == ST_CHECK) && flush_q && (pending_q == '0)) begin
        flush_q        <= 1'b0;
        outputs_done_q <= '0;
      end
      if (out_load) begin
        pending_q <= pending_q - PEND_W'(1);
        if (32'(outputs_done_q) < MAX_HALF) begin
          outputs_done_q <= outputs_done_q + H_W'(1);
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      h_q        <= h_sel;
      last_res_q <= flush_q && (pending_q == PEND_W'(1));
      rd_addr_q  <= PTR_W'(start_addr);
      cnt_q      <= '0;
      acc_q      <= '0;
    end else begin
      if (state_q == ST_SUM) begin
        rd_addr_q <= (32'(rd_addr_q) == LINE_DEPTH - 1) ? '0 : rd_addr_q + PTR_W'(1);
        cnt_q     <= cnt_q + CNT_W'(1);
      end
      if (rd_valid_q) begin
        acc_q <= acc_q + {{(SUM_W - SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
      end
    end
    if (out_load) begin
      smoothed_q <= quotient[SAMPLE_BITS-1:0];
      out_last_q <= last_res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign smoothed_o    = smoothed_q;
  assign last_result_o = out_last_q;

  // ---------------------------------------------------------------- units
  cma_line #(
    .DATA_W (SAMPLE_BITS),
    .DEPTH  (LINE_DEPTH),
    .AW     (PTR_W)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wr_ptr_q),
    .wdata_i (sample_i),
    .re_i    (state_q == ST_SUM),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  cma_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (DIV_W'({h_q, 1'b1})),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

`ifndef SYNTHESIS
  a_pending_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (pending_q == $past(pending_q) + PEND_W'(1)))
    else $error("pending count did not advance on an accepted item");

  a_last_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_res_q) |-> (pending_q == PEND_W'(1) && flush_q))
    else $error("final result loaded while results remain");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!flush_q && (32'(pending_q) <= MAX_HALF)))
    else $error("idle with a pending flush or too many waiting samples");
`endif

endmodule
`default_nettype wire

// ----- bench/cma_checker.sv -----
// Checker for the centered moving average: watches all channels, predicts results, compares.
module cma_checker #(
  parameter int unsigned MAX_HALF    = 31,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic                                 last_sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]        smoothed_i,
  input  logic                                 last_result_i,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cma_pkg::PADDR_W-1:0]          paddr,
  input  logic [cma_pkg::PDATA_W-1:0]          pwdata,
  input  logic [cma_pkg::PDATA_W-1:0]          prdata,
  input  logic                                 pready,
  output int unsigned                          fail_count_o,
  output int unsigned                          waiting_means_o
);
  import cma_pkg::*;

  localparam int unsigned LINE_DEPTH = 2 * MAX_HALF + 1;
  localparam int unsigned BURST_CAP  = 32;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          last_result;
  } window_mean_t;

  window_mean_t                  expected_means[$];
  logic signed [SAMPLE_BITS-1:0] trace_ring[LINE_DEPTH];
  int unsigned                   ring_wr;
  int unsigned                   unsent_cnt;
  int unsigned                   emitted_cnt;
  logic [HALF_W-1:0]             half_width_q;

  function automatic longint ring_back(input int unsigned back);
    int unsigned idx;
    idx = (ring_wr + 2 * LINE_DEPTH - 1 - (back % LINE_DEPTH)) % LINE_DEPTH;
    return longint'(trace_ring[idx]);
  endfunction

  function automatic int unsigned umin(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count_o < REPORT_MAX) $display("%0t: %s", $realtime, msg);
    fail_count_o++;
  endfunction

  // Average the window centered on the oldest unsent sample and queue it.
  task automatic push_window_mean(input int unsigned h, input logic last_flag);
    int unsigned  center;
    longint       acc;
    longint       mean;
    window_mean_t entry;
    center = unsent_cnt - 1;
    acc = 0;
    for (int unsigned b = center - h; b <= center + h; b++) acc += ring_back(b);
    mean = acc / longint'(2 * h + 1);
    entry.smoothed = mean[SAMPLE_BITS-1:0];
    entry.last_result = last_flag;
    expected_means.push_back(entry);
    unsent_cnt--;
    if (emitted_cnt < MAX_HALF) emitted_cnt++;
  endtask

  task automatic smooth_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last_flag);
    int unsigned heff;
    int unsigned k;
    heff = umin(32'(half_width_q), MAX_HALF);
    k = 0;
    trace_ring[ring_wr] = s;
    ring_wr = (ring_wr + 1) % LINE_DEPTH;
    unsent_cnt++;
    if (last_flag) begin
      // flush: the window shrinks toward the trace end
      while (unsent_cnt > 0 && k < BURST_CAP) begin
        push_window_mean(umin(umin(emitted_cnt, heff), unsent_cnt - 1), unsent_cnt == 1);
        k++;
      end
      unsent_cnt = 0;
      emitted_cnt = 0;
    end else begin
      while (unsent_cnt > 0 && k < BURST_CAP &&
             unsent_cnt - 1 >= umin(emitted_cnt, heff)) begin
        push_window_mean(umin(emitted_cnt, heff), 1'b0);
        k++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_mean_t want;
    if (!rst_ni) begin
      expected_means.delete();
      foreach (trace_ring[i]) trace_ring[i] = '0;
      ring_wr = 0;
      unsent_cnt = 0;
      emitted_cnt = 0;
      half_width_q = HALF_RESET;
      fail_count_o = 0;
      waiting_means_o = 0;
    end else begin
      // compare before predicting: a result at this edge predates any item taken now
      if (out_valid_i && !out_stall_i) begin
        if (expected_means.size() == 0) begin
          note_failure($sformatf("unexpected item: smoothed %0d last %0b",
                                 smoothed_i, last_result_i));
        end else begin
          want = expected_means.pop_front();
          if (smoothed_i !== want.smoothed || last_result_i !== want.last_result)
            note_failure($sformatf("smoothed exp %0d got %0d, last exp %0b got %0b",
                                   want.smoothed, smoothed_i, want.last_result,
                                   last_result_i));
        end
      end
      if (in_valid_i && !in_stall_i) smooth_sample(sample_i, last_sample_i);
      if (psel && penable && pready && (paddr >> 2) == REG_HALF_WIDTH) begin
        if (pwrite) begin
          half_width_q = pwdata[HALF_W-1:0];
        end else if (prdata[HALF_W-1:0] !== half_width_q) begin
          note_failure($sformatf("half_width read exp %0d got %0d",
                                 half_width_q, prdata[HALF_W-1:0]));
        end
      end
      waiting_means_o = expected_means.size();
    end
  end

endmodule

// ----- bench/centered_moving_average_tb.sv -----
// Testbench top for the centered moving average: clock, reset, stimulus and verdict.
module centered_moving_average_tb;
  import cma_pkg::*;

  localparam int unsigned MAX_HALF     = 31;
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned PHASE_ITEMS  = 40;
  localparam int unsigned IDLE_GAP     = 150;
  localparam int unsigned END_GAP      = 300;
  localparam int unsigned HOLD_AFTER   = 40;
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned MAX_WAIT     = 5;

  localparam logic [PADDR_W-1:0] HALF_WIDTH_ADDR = PADDR_W'(REG_HALF_WIDTH) << 2;
  localparam logic [PADDR_W-1:0] SPARE_ADDR      =
    PADDR_W'((PADDR_W'(REG_HALF_WIDTH) + 1) << 2);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          last_sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [SAMPLE_BITS-1:0] smoothed_o;
  logic                          last_result_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [PADDR_W-1:0]            paddr;
  logic [PDATA_W-1:0]            pwdata;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;
  int unsigned                   fail_count;
  int unsigned                   waiting_means;
  int unsigned                   cycle_count = 0;
  int unsigned                   send_calm = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  centered_moving_average #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .smoothed_o   (smoothed_o),
    .last_result_o(last_result_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  cma_checker #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .sample_i       (sample_i),
    .last_sample_i  (last_sample_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smoothed_i     (smoothed_o),
    .last_result_i  (last_result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .waiting_means_o(waiting_means)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall before each item, calm stretches, one long hold-off.
  initial begin
    int unsigned taken;
    int unsigned wait_cycles;
    int unsigned calm;
    bit          held;
    taken = 0;
    calm = 0;
    held = 1'b0;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (taken == HOLD_AFTER && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (calm > 0) begin
        calm--;
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 30);
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last_flag);
    int unsigned wait_cycles;
    if (send_calm > 0) begin
      send_calm--;
      wait_cycles = 0;
    end else begin
      wait_cycles = $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 30);
    end
    if (wait_cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (wait_cycles) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_sample_i <= last_flag;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic write_en, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write_en;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop valid and let the block drain before touching the register.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (waiting_means != 0) @(negedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  initial begin
    int unsigned                   sent;
    int unsigned                   phase_sent;
    int unsigned                   phase;
    int unsigned                   trace_len;
    int unsigned                   kind;
    logic [HALF_W-1:0]             phase_half;
    logic [PDATA_W-1:0]            word;
    logic signed [SAMPLE_BITS-1:0] s_val;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    last_sample_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset width, alternating extremes, single and two-sample traces
    apb_access(1'b0, HALF_WIDTH_ADDR, '0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_BITS'(-1), 1'b1);
    // widest setting on a trace far shorter than the window
    settle();
    apb_access(1'b1, HALF_WIDTH_ADDR, PDATA_W'(MAX_HALF));
    send_sample(SAMPLE_BITS'(1), 1'b0);
    send_sample(SAMPLE_BITS'(2), 1'b0);
    send_sample(SAMPLE_BITS'(3), 1'b0);
    send_sample(SAMPLE_BITS'(4), 1'b1);
    // narrow the window while samples are still waiting for their windows
    settle();
    apb_access(1'b1, HALF_WIDTH_ADDR, 3);
    send_sample(SAMPLE_BITS'(10), 1'b0);
    send_sample(SAMPLE_BITS'(-20), 1'b0);
    send_sample(SAMPLE_BITS'(30), 1'b0);
    send_sample(SAMPLE_BITS'(-40), 1'b0);
    send_sample(SAMPLE_BITS'(50), 1'b0);
    settle();
    apb_access(1'b1, HALF_WIDTH_ADDR, 1);
    send_sample(SAMPLE_BITS'(-60), 1'b0);
    send_sample(SAMPLE_BITS'(70), 1'b1);
    // write to an unmapped address must not disturb the width
    settle();
    apb_access(1'b1, SPARE_ADDR, '1);
    apb_access(1'b0, HALF_WIDTH_ADDR, '0);
    apb_access(1'b1, HALF_WIDTH_ADDR, 0);
    send_sample(SAMPLE_BITS'(0), 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    settle();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 6)
        0: phase_half = HALF_W'(MAX_HALF);
        1: phase_half = '0;
        2: phase_half = HALF_W'(1);
        default: phase_half = HALF_W'($urandom_range(0, MAX_HALF));
      endcase
      word = $urandom();
      word[HALF_W-1:0] = phase_half;
      apb_access(1'b1, SPARE_ADDR, $urandom());
      apb_access(1'b1, HALF_WIDTH_ADDR, word);
      apb_access(1'b0, HALF_WIDTH_ADDR, '0);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) trace_len = $urandom_range(40, 70);
        else trace_len = $urandom_range(1, 2 * phase_half + 4);
        for (int unsigned i = 0; i < trace_len; i++) begin
          kind = $urandom_range(0, 9);
          case (kind)
            0: s_val = SAMPLE_MAX;
            1: s_val = SAMPLE_MIN;
            2, 3, 4: s_val = SAMPLE_BITS'($signed($urandom_range(0, 200)) - 100);
            default: s_val = SAMPLE_BITS'($urandom());
          endcase
          send_sample(s_val, i == trace_len - 1);
          sent++;
          phase_sent++;
        end
      end
      settle();
      phase++;
    end

    in_valid_i <= 1'b0;
    while (waiting_means != 0) @(negedge clk_i);
    repeat (END_GAP) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
